FILE: hw/rtl/fpp_pkg.sv
// fpp_pkg: shared types and fixed widths for the farthest point pair block
// no dependencies; imported by fpp_front, fpp_job_queue, fpp_back and the top level
package fpp_pkg;

    localparam int IDX_OUT_W  = 6;
    localparam int DIST_OUT_W = 17;

    typedef struct packed {
        logic not_empty;
        logic full;
    } fpp_q_status_t;

    typedef struct packed {
        logic pop;
        logic retire;
    } fpp_q_cmd_t;

endpackage

FILE: hw/rtl/fpp_front.sv
// fpp_front: accepts points, writes them to the active bank of the point store
// and posts one job per set to the job queue; depends on fpp_pkg
module fpp_front #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_WIDTH-1:0]  coord_x,
    input  logic signed [COORD_WIDTH-1:0]  coord_y,
    input  logic                           last_point,
    input  fpp_pkg::fpp_q_status_t         q_status,
    output logic                           job_push,
    output logic [CNT_W:0]                 job_data,
    output logic                           wr_en,
    output logic [IDX_W:0]                 wr_addr,
    output logic [2*COORD_WIDTH-1:0]       wr_data
);
    import fpp_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_after;
    logic             bank_reg;
    logic             bank_next;
    logic             accept;
    logic             has_room;

    assign in_stall    = q_status.full;
    assign accept      = in_valid && !in_stall;
    assign has_room    = count_reg < CNT_W'(MAX_POINTS);
    assign count_after = has_room ? count_reg + CNT_W'(1) : count_reg;

    assign wr_en   = accept && has_room;
    assign wr_addr = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data = {coord_x, coord_y};

    assign job_push = accept && last_point;
    assign job_data = {bank_reg, count_after};

    always_comb
    begin
        count_next = count_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (last_point)
            begin
                count_next = '0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

FILE: hw/rtl/fpp_job_queue.sv
// fpp_job_queue: two-entry queue of finished sets between front and back,
// also counts sets that still own a store bank; depends on fpp_pkg
module fpp_job_queue #(
    parameter int JOB_W = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    job_push,
    input  logic [JOB_W-1:0]        job_data,
    input  fpp_pkg::fpp_q_cmd_t     q_cmd,
    output fpp_pkg::fpp_q_status_t  q_status,
    output logic [JOB_W-1:0]        q_head
);
    import fpp_pkg::*;

    logic [JOB_W-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic [1:0]       owed_reg;
    logic [1:0]       owed_next;

    assign q_head             = entry_reg[rd_ptr_reg];
    assign q_status.not_empty = fill_reg != 2'd0;
    assign q_status.full      = owed_reg == 2'd2;

    always_comb
    begin
        unique case ({job_push, q_cmd.pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
        unique case ({job_push, q_cmd.retire})
            2'b10:   owed_next = owed_reg + 2'd1;
            2'b01:   owed_next = owed_reg - 2'd1;
            default: owed_next = owed_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_push)
        begin
            entry_reg[wr_ptr_reg] <= job_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            owed_reg   <= 2'd0;
        end
        else
        begin
            if (job_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_cmd.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
            owed_reg <= owed_next;
        end
    end

endmodule

FILE: hw/rtl/fpp_back.sv
// fpp_back: point store, pair sequencer, distance pipeline with a pipelined
// integer square root, running maximum and result register; depends on fpp_pkg
module fpp_back #(
    parameter int COORD_WIDTH = 16,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [IDX_W:0]                        wr_addr,
    input  logic [2*COORD_WIDTH-1:0]              wr_data,
    input  fpp_pkg::fpp_q_status_t                q_status,
    input  logic [CNT_W:0]                        q_head,
    output fpp_pkg::fpp_q_cmd_t                   q_cmd,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [fpp_pkg::IDX_OUT_W-1:0]         first_index,
    output logic [fpp_pkg::IDX_OUT_W-1:0]         second_index,
    output logic [fpp_pkg::DIST_OUT_W-1:0]        max_distance,
    output logic                                  too_few_points
);
    import fpp_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int SQ_W   = 2 * CW;
    localparam int SUM_W  = 2 * CW + 1;
    localparam int S_W    = 2 * CW + 2;
    localparam int R_W    = CW + 1;
    localparam int REM_W  = R_W + 3;
    localparam int ADDR_W = IDX_W + 1;
    localparam int DEPTH  = 2 ** ADDR_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_ISSUE  = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             bank_reg;
    logic             bank_next;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [IDX_W-1:0] pi_reg;
    logic [IDX_W-1:0] pi_next;
    logic [IDX_W-1:0] pj_reg;
    logic [IDX_W-1:0] pj_next;

    logic             issue;
    logic             first_pair;
    logic             row_end;
    logic             last_pair;
    logic             start_job;
    logic             head_few;
    logic [CNT_W-1:0] head_n;

    // point store, two banks
    logic [SQ_W-1:0]  store_mem [DEPTH];
    logic [SQ_W-1:0]  rd_a_reg;
    logic [SQ_W-1:0]  rd_b_reg;

    // pipeline stages after the store read
    logic             v1_reg, f1_reg, l1_reg;
    logic [IDX_W-1:0] i1_reg, j1_reg;
    logic             v2_reg, f2_reg, l2_reg;
    logic [IDX_W-1:0] i2_reg, j2_reg;
    logic [CW-1:0]    dx2_reg, dy2_reg;
    logic             v3_reg, f3_reg, l3_reg;
    logic [IDX_W-1:0] i3_reg, j3_reg;
    logic [SQ_W-1:0]  sqx3_reg, sqy3_reg;
    logic             v4_reg, f4_reg, l4_reg;
    logic [IDX_W-1:0] i4_reg, j4_reg;
    logic [SUM_W-1:0] sum4_reg;

    logic signed [CW:0] diff_x;
    logic signed [CW:0] diff_y;
    logic [CW:0]        abs_x;
    logic [CW:0]        abs_y;

    // square root stages, one result bit each
    logic [REM_W-1:0] sq_rem_reg  [R_W];
    logic [R_W-1:0]   sq_root_reg [R_W];
    logic [S_W-1:0]   sq_sum_reg  [R_W];
    logic             sq_v_reg    [R_W];
    logic             sq_f_reg    [R_W];
    logic             sq_l_reg    [R_W];
    logic [IDX_W-1:0] sq_i_reg    [R_W];
    logic [IDX_W-1:0] sq_j_reg    [R_W];
    logic [REM_W-1:0] rem_c       [R_W];
    logic [R_W-1:0]   root_c      [R_W];
    logic [S_W-1:0]   sum_c       [R_W];

    logic             dv, df, dl;
    logic [R_W-1:0]   pair_dist;
    logic [IDX_W-1:0] di, dj;

    logic [R_W-1:0]   best_d_reg;
    logic [IDX_W-1:0] bi_reg;
    logic [IDX_W-1:0] bj_reg;
    logic             few_reg;

    assign head_n     = q_head[CNT_W-1:0];
    assign head_few   = head_n < CNT_W'(2);
    assign start_job  = (state_reg == ST_IDLE) && q_status.not_empty;
    assign issue      = state_reg == ST_ISSUE;
    assign first_pair = (pi_reg == '0) && (pj_reg == IDX_W'(1));
    assign row_end    = (CNT_W'(pj_reg) + CNT_W'(1)) == n_reg;
    assign last_pair  = row_end && ((CNT_W'(pi_reg) + CNT_W'(2)) == n_reg);

    assign q_cmd.pop    = start_job;
    assign q_cmd.retire = (state_reg == ST_RESULT) && !out_stall;

    // pair sequencer
    always_comb
    begin
        state_next = state_reg;
        bank_next  = bank_reg;
        n_next     = n_reg;
        pi_next    = pi_reg;
        pj_next    = pj_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    bank_next  = q_head[CNT_W];
                    n_next     = head_n;
                    pi_next    = '0;
                    pj_next    = IDX_W'(1);
                    state_next = head_few ? ST_RESULT : ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                priority if (last_pair)
                begin
                    state_next = ST_DRAIN;
                end
                else if (row_end)
                begin
                    pi_next = pi_reg + IDX_W'(1);
                    pj_next = pi_reg + IDX_W'(2);
                end
                else
                begin
                    pj_next = pj_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (dv && dl)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bank_reg  <= 1'b0;
            n_reg     <= '0;
            pi_reg    <= '0;
            pj_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            n_reg     <= n_next;
            pi_reg    <= pi_next;
            pj_reg    <= pj_next;
        end
    end

    // store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= store_mem[{bank_reg, pi_reg}];
        rd_b_reg <= store_mem[{bank_reg, pj_reg}];
    end

    // absolute coordinate differences
    always_comb
    begin
        diff_x = $signed({rd_a_reg[SQ_W-1], rd_a_reg[SQ_W-1:CW]})
               - $signed({rd_b_reg[SQ_W-1], rd_b_reg[SQ_W-1:CW]});
        diff_y = $signed({rd_a_reg[CW-1], rd_a_reg[CW-1:0]})
               - $signed({rd_b_reg[CW-1], rd_b_reg[CW-1:0]});
        abs_x  = diff_x[CW] ? (~diff_x + 1'b1) : diff_x;
        abs_y  = diff_y[CW] ? (~diff_y + 1'b1) : diff_y;
    end

    // restoring square root, one result bit per stage
    always_comb
    begin
        logic [REM_W-1:0] src_rem;
        logic [R_W-1:0]   src_root;
        logic [S_W-1:0]   src_sum;
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        for (int s = 0; s < R_W; s++)
        begin
            if (s == 0)
            begin
                src_rem  = '0;
                src_root = '0;
                src_sum  = {1'b0, sum4_reg};
            end
            else
            begin
                src_rem  = sq_rem_reg[s-1];
                src_root = sq_root_reg[s-1];
                src_sum  = sq_sum_reg[s-1];
            end
            rem_sh = {src_rem[REM_W-3:0], src_sum[S_W-1:S_W-2]};
            trial  = REM_W'({src_root, 2'b01});
            if (rem_sh >= trial)
            begin
                rem_c[s]  = rem_sh - trial;
                root_c[s] = {src_root[R_W-2:0], 1'b1};
            end
            else
            begin
                rem_c[s]  = rem_sh;
                root_c[s] = {src_root[R_W-2:0], 1'b0};
            end
            sum_c[s] = {src_sum[S_W-3:0], 2'b00};
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        i1_reg   <= pi_reg;
        j1_reg   <= pj_reg;
        f1_reg   <= first_pair;
        l1_reg   <= last_pair;
        i2_reg   <= i1_reg;
        j2_reg   <= j1_reg;
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg;
        dx2_reg  <= abs_x[CW-1:0];
        dy2_reg  <= abs_y[CW-1:0];
        i3_reg   <= i2_reg;
        j3_reg   <= j2_reg;
        f3_reg   <= f2_reg;
        l3_reg   <= l2_reg;
        sqx3_reg <= SQ_W'(dx2_reg) * SQ_W'(dx2_reg);
        sqy3_reg <= SQ_W'(dy2_reg) * SQ_W'(dy2_reg);
        i4_reg   <= i3_reg;
        j4_reg   <= j3_reg;
        f4_reg   <= f3_reg;
        l4_reg   <= l3_reg;
        sum4_reg <= SUM_W'(sqx3_reg) + SUM_W'(sqy3_reg);
        for (int s = 0; s < R_W; s++)
        begin
            sq_rem_reg[s]  <= rem_c[s];
            sq_root_reg[s] <= root_c[s];
            sq_sum_reg[s]  <= sum_c[s];
            if (s == 0)
            begin
                sq_i_reg[s] <= i4_reg;
                sq_j_reg[s] <= j4_reg;
                sq_f_reg[s] <= f4_reg;
                sq_l_reg[s] <= l4_reg;
            end
            else
            begin
                sq_i_reg[s] <= sq_i_reg[s-1];
                sq_j_reg[s] <= sq_j_reg[s-1];
                sq_f_reg[s] <= sq_f_reg[s-1];
                sq_l_reg[s] <= sq_l_reg[s-1];
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int s = 0; s < R_W; s++)
            begin
                sq_v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            for (int s = 0; s < R_W; s++)
            begin
                if (s == 0)
                begin
                    sq_v_reg[s] <= v4_reg;
                end
                else
                begin
                    sq_v_reg[s] <= sq_v_reg[s-1];
                end
            end
        end
    end

    assign dv        = sq_v_reg[R_W-1];
    assign df        = sq_f_reg[R_W-1];
    assign dl        = sq_l_reg[R_W-1];
    assign pair_dist = sq_root_reg[R_W-1];
    assign di        = sq_i_reg[R_W-1];
    assign dj        = sq_j_reg[R_W-1];

    // running maximum, first pair seeds it, ties keep the earlier pair
    always_ff @(posedge clk)
    begin
        priority if (start_job && head_few)
        begin
            best_d_reg <= '0;
            bi_reg     <= '0;
            bj_reg     <= '0;
            few_reg    <= 1'b1;
        end
        else if (dv && (df || (pair_dist > best_d_reg)))
        begin
            best_d_reg <= pair_dist;
            bi_reg     <= di;
            bj_reg     <= dj;
            few_reg    <= 1'b0;
        end
    end

    assign out_valid      = state_reg == ST_RESULT;
    assign first_index    = IDX_OUT_W'(bi_reg);
    assign second_index   = IDX_OUT_W'(bj_reg);
    assign max_distance   = DIST_OUT_W'(best_d_reg);
    assign too_few_points = few_reg;

endmodule

FILE: hw/rtl/farthest_point_pair.sv
// farthest_point_pair: points load one per cycle (x, y, last_point); the transaction
// with last_point closes the set and the block returns one result: the first pair
// i<j in row order with the largest floor Euclidean distance, or too_few_points when
// the set held fewer than two points. Up to MAX_POINTS points per set are stored;
// later points are dropped but a last_point still closes the set. The search reads
// two points a cycle from a dual-read store and runs one pair per cycle through a
// difference, square, sum and a COORD_WIDTH+1 stage square root pipeline. The store
// has two banks: the next set loads while one is searched, and input stalls only once
// two closed sets are waiting, in search or holding their result.
module farthest_point_pair #(
    parameter int MAX_POINTS  = 64,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COORD_WIDTH-1:0]         coord_x,
    input  logic signed [COORD_WIDTH-1:0]         coord_y,
    input  logic                                  last_point,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [fpp_pkg::IDX_OUT_W-1:0]         first_index,
    output logic [fpp_pkg::IDX_OUT_W-1:0]         second_index,
    output logic [fpp_pkg::DIST_OUT_W-1:0]        max_distance,
    output logic                                  too_few_points
);
    import fpp_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    fpp_q_status_t            q_status;
    fpp_q_cmd_t               q_cmd;
    logic                     job_push;
    logic [CNT_W:0]           job_data;
    logic [CNT_W:0]           q_head;
    logic                     wr_en;
    logic [IDX_W:0]           wr_addr;
    logic [2*COORD_WIDTH-1:0] wr_data;

    fpp_front #(
        .MAX_POINTS  (MAX_POINTS),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .last_point (last_point),
        .q_status   (q_status),
        .job_push   (job_push),
        .job_data   (job_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    fpp_job_queue #(
        .JOB_W (CNT_W + 1)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_push (job_push),
        .job_data (job_data),
        .q_cmd    (q_cmd),
        .q_status (q_status),
        .q_head   (q_head)
    );

    fpp_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .q_status       (q_status),
        .q_head         (q_head),
        .q_cmd          (q_cmd),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .first_index    (first_index),
        .second_index   (second_index),
        .max_distance   (max_distance),
        .too_few_points (too_few_points)
    );

`ifndef SYNTH
    a_push_has_bank: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !q_status.full)
        else $error("set closed with both store banks in use");

    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_cmd.pop |-> q_status.not_empty)
        else $error("job taken from an empty queue");

    a_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && too_few_points) |->
            (first_index == '0 && second_index == '0 && max_distance == '0))
        else $error("short set result carries nonzero fields");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated after transaction");
`endif

endmodule
